>>> rtl/roman_numeral_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// roman numeral encoder assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define RNE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("roman encoder assertion failed");

// next-cycle implication
`define RNE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("roman encoder assertion failed");

`endif

>>> rtl/rnenc_pkg.sv
// ----------------------------------------------------------------------------
// rnenc_pkg
// types, codes and numeral tables shared by the roman numeral encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rnenc_pkg;

  localparam int unsigned NUM_W    = 12;
  localparam int unsigned SYM_W    = 7;
  localparam int unsigned CNT_W    = 4;
  localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(3999);

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // letter role within one decimal place
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  // ascii letters
  localparam logic [SYM_W-1:0] CH_I = 7'h49;
  localparam logic [SYM_W-1:0] CH_V = 7'h56;
  localparam logic [SYM_W-1:0] CH_X = 7'h58;
  localparam logic [SYM_W-1:0] CH_L = 7'h4C;
  localparam logic [SYM_W-1:0] CH_C = 7'h43;
  localparam logic [SYM_W-1:0] CH_D = 7'h44;
  localparam logic [SYM_W-1:0] CH_M = 7'h4D;

  // one classified numeral, handed from front to back
  typedef struct packed {
    logic [3:0][3:0]   digits;  // bcd, [3] is thousands
    logic [1:0]        status;
    logic [CNT_W-1:0]  keep;    // letters to emit, 0 means empty result
  } job_t;

  // letters needed for one decimal digit
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // which letter of the place stands at position pos of digit d
  function automatic logic [1:0] digit_sel(input logic [3:0] d, input logic [1:0] pos);
    logic [1:0] s;
    case (d)
      4'd4:                s = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
      4'd5:                s = SEL_FIVE;
      4'd6, 4'd7, 4'd8:    s = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
      4'd9:                s = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
      default:             s = SEL_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] place_letter(input logic [1:0] place,
                                                    input logic [1:0] sel);
    logic [SYM_W-1:0] c;
    case (place)
      2'd0:    c = (sel == SEL_ONE) ? CH_I : (sel == SEL_FIVE) ? CH_V : CH_X;
      2'd1:    c = (sel == SEL_ONE) ? CH_X : (sel == SEL_FIVE) ? CH_L : CH_C;
      2'd2:    c = (sel == SEL_ONE) ? CH_C : (sel == SEL_FIVE) ? CH_D : CH_M;
      default: c = CH_M;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rnenc_front.sv
// ----------------------------------------------------------------------------
// rnenc_front
// accepts numbers, range-checks them, converts to bcd and sizes the numeral
// ----------------------------------------------------------------------------
`default_nettype none

module rnenc_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [rnenc_pkg::NUM_W-1:0] in_number,
  output logic                            in_stall,
  input  wire logic [rnenc_pkg::CNT_W-1:0] max_chars,
  output logic                            push,
  output rnenc_pkg::job_t                 push_job,
  input  wire logic                       full
);
  import rnenc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_PUSH} state_t;

  state_t           state_r;
  logic [15:0]      bcd_r;
  logic [NUM_W-1:0] bin_r;
  logic [3:0]       step_r;
  logic             range_r;

  logic [15:0]      bcd_adj;
  logic [4:0]       len;
  logic             accept;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // add-3 correction ahead of each shift
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      bcd_adj[n*4 +: 4] = (bcd_r[n*4 +: 4] >= 4'd5) ? bcd_r[n*4 +: 4] + 4'd3
                                                    : bcd_r[n*4 +: 4];
    end
  end

  always_comb begin
    len = 5'(digit_len(bcd_r[15:12])) + 5'(digit_len(bcd_r[11:8]))
        + 5'(digit_len(bcd_r[7:4]))   + 5'(digit_len(bcd_r[3:0]));
  end

  always_comb begin
    push_job.digits = bcd_r;
    if (range_r) begin
      push_job.status = ST_RANGE;
      push_job.keep   = '0;
    end else if (len > {1'b0, max_chars}) begin
      push_job.status = ST_TRUNC;
      push_job.keep   = max_chars;
    end else begin
      push_job.status = ST_OK;
      push_job.keep   = len[CNT_W-1:0];
    end
  end

  assign push = (state_r == S_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      range_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            bcd_r   <= '0;
            bin_r   <= in_number;
            step_r  <= '0;
            range_r <= (in_number == '0) || (in_number > NUM_MAX);
            state_r <= ((in_number == '0) || (in_number > NUM_MAX)) ? S_PUSH : S_CONV;
          end
        end
        S_CONV: begin
          {bcd_r, bin_r} <= {bcd_adj, bin_r} << 1;
          step_r         <= step_r + 4'd1;
          if (step_r == 4'(NUM_W - 1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rnenc_fifo.sv
// ----------------------------------------------------------------------------
// rnenc_fifo
// short queue of classified numerals between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rnenc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rnenc_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output rnenc_pkg::job_t      head_job,
  output logic                 empty
);
  import rnenc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop && !empty) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill_r <= fill_r + CW'(1);
        2'b01:   fill_r <= fill_r - CW'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rnenc_back.sv
// ----------------------------------------------------------------------------
// rnenc_back
// walks the bcd digits of a numeral and emits one letter per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module rnenc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rnenc_pkg::job_t             head_job,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rnenc_pkg::SYM_W-1:0]      out_symbol,
  output logic                             out_has_symbol,
  output logic [1:0]                       out_status,
  output logic [rnenc_pkg::CNT_W-1:0]      out_char_count,
  output logic                             out_last
);
  import rnenc_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state_r;
  logic [3:0][3:0]  dig_r;
  logic [1:0]       place_r;
  logic [1:0]       pos_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] keep_r;
  logic [1:0]       status_r;

  logic             out_valid_r;
  logic [SYM_W-1:0] out_symbol_r;
  logic             out_has_symbol_r;
  logic [1:0]       out_status_r;
  logic [CNT_W-1:0] out_char_count_r;
  logic             out_last_r;

  logic             out_ld;
  logic [1:0]       first_place;
  logic [1:0]       next_place;
  logic             found_next;
  logic [CNT_W-1:0] count_inc;
  logic             run_last;
  logic             digit_done;

  assign out_ld = !out_valid_r || !out_stall;
  assign pop    = (state_r == S_IDLE) && !empty && out_ld;

  assign out_valid      = out_valid_r;
  assign out_symbol     = out_symbol_r;
  assign out_has_symbol = out_has_symbol_r;
  assign out_status     = out_status_r;
  assign out_char_count = out_char_count_r;
  assign out_last       = out_last_r;

  // highest place with letters in the queued numeral
  always_comb begin
    first_place = 2'd0;
    for (int p = 0; p < 4; p++) begin
      if (digit_len(head_job.digits[p]) != 3'd0) begin
        first_place = 2'(p);
      end
    end
  end

  // next lower place with letters
  always_comb begin
    next_place = 2'd0;
    found_next = 1'b0;
    for (int p = 2; p >= 0; p--) begin
      if (!found_next && (p < int'(place_r)) && (digit_len(dig_r[p]) != 3'd0)) begin
        next_place = 2'(p);
        found_next = 1'b1;
      end
    end
  end

  assign count_inc  = count_r + CNT_W'(1);
  assign run_last   = (count_inc == keep_r);
  assign digit_done = (({1'b0, pos_r} + 3'd1) == digit_len(dig_r[place_r]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ld) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            dig_r    <= head_job.digits;
            keep_r   <= head_job.keep;
            status_r <= head_job.status;
            place_r  <= first_place;
            pos_r    <= '0;
            count_r  <= '0;
            if (head_job.keep == '0) begin
              // empty run: one result with no letter
              out_valid_r      <= 1'b1;
              out_symbol_r     <= '0;
              out_has_symbol_r <= 1'b0;
              out_status_r     <= head_job.status;
              out_char_count_r <= '0;
              out_last_r       <= 1'b1;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (out_ld) begin
            out_valid_r      <= 1'b1;
            out_symbol_r     <= place_letter(place_r, digit_sel(dig_r[place_r], pos_r));
            out_has_symbol_r <= 1'b1;
            out_status_r     <= status_r;
            out_char_count_r <= count_inc;
            out_last_r       <= run_last;
            count_r          <= count_inc;
            if (digit_done) begin
              place_r <= next_place;
              pos_r   <= '0;
            end else begin
              pos_r <= pos_r + 2'd1;
            end
            if (run_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// integer to subtractive roman numeral, one ascii letter per output transaction
// ----------------------------------------------------------------------------
// Each accepted number (1..3999) comes out as a run of letters I V X L C D M,
// most significant first, one per output transaction, the final one marked by
// out_last. Every result of a run carries the same status: ok, out of range
// (number 0 or above 3999, one empty result), or truncated when the numeral is
// longer than cfg max_chars (reset 15); a limit of zero gives one empty
// truncated result. The front takes a number, range-checks it and converts it
// to bcd with a shift-and-add-3 loop of one bit per cycle, and stays busy until
// the job is pushed into the queue; an out-of-range number skips the loop. The
// back pops one queued job and then emits one letter per cycle while the output
// is not stalled, with the queue letting the front convert the next number
// while the back still emits. The output is registered, so a stall on the
// result side holds the back directly and reaches the front once the queue is full.
`default_nettype none

module roman_numeral_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // number in
  input  wire logic                        in_valid,
  input  wire logic [rnenc_pkg::NUM_W-1:0] in_number,
  output logic                             in_stall,
  // letters out
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rnenc_pkg::SYM_W-1:0]      out_symbol,
  output logic                             out_has_symbol,
  output logic [1:0]                       out_status,
  output logic [rnenc_pkg::CNT_W-1:0]      out_char_count,
  output logic                             out_last,
  // max_chars register
  input  wire logic                        cfg_wr_en,
  input  wire logic [rnenc_pkg::CNT_W-1:0] cfg_wr_data
);
  import rnenc_pkg::*;

  // character limit, to be written by the user only while idle; the block does not enforce this
  logic [CNT_W-1:0] max_chars_r;

  // front to queue
  logic push;
  job_t push_job;
  logic full;

  // queue to back
  logic pop;
  job_t head_job;
  logic empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= CNT_W'(15);
    end else if (cfg_wr_en) begin
      max_chars_r <= cfg_wr_data;
    end
  end

  // range check and bcd conversion
  rnenc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_number (in_number),
    .in_stall  (in_stall),
    .max_chars (max_chars_r),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  // decouples conversion from letter emission
  rnenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  // letter sequencer with output register
  rnenc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_has_symbol (out_has_symbol),
    .out_status     (out_status),
    .out_char_count (out_char_count),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> rtl/rnenc_checker.sv
// ----------------------------------------------------------------------------
// rnenc_checker
// port-level assertions for the roman numeral encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "roman_numeral_encoder_top_assert.svh"

module rnenc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rnenc_pkg::SYM_W-1:0] out_symbol,
  input wire logic                        out_has_symbol,
  input wire logic [1:0]                  out_status,
  input wire logic [rnenc_pkg::CNT_W-1:0] out_char_count,
  input wire logic                        out_last
);
  import rnenc_pkg::*;

  // a stalled result holds
  `RNE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_symbol) && $stable(out_has_symbol) && $stable(out_status) && $stable(out_char_count) && $stable(out_last))

  // an empty result always closes its run
  `RNE_ASSERT_IMP(a_empty_last, out_valid && !out_has_symbol, out_last && (out_char_count == '0))

  // out of range never carries a letter
  `RNE_ASSERT_IMP(a_range_empty, out_valid && (out_status == ST_RANGE), !out_has_symbol)

  // a letter always counts at least one
  `RNE_ASSERT_IMP(a_letter_count, out_valid && out_has_symbol, out_char_count != '0)

  // the front is busy right after taking a number
  `RNE_ASSERT_NXT(a_front_busy, in_valid && !in_stall, in_stall)

endmodule

bind roman_numeral_encoder_top rnenc_checker u_rnenc_checker (.*);

`default_nettype wire
